// ===== rtl/tsp_pkg.sv =====
// types and constants shared by the timed slot pool
package tsp_pkg;

  localparam int unsigned FRAMES = 4;
  localparam int unsigned AGE_W = 9;
  localparam logic [7:0] LIFETIME_RESET = 8'd13;

  typedef enum logic [1:0] {
    FN_ADD   = 2'd0,
    FN_TICK  = 2'd1,
    FN_READ  = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    func_t              func;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic               kind;
    logic [7:0]         slot_index;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [7:0]         slot_out;
    logic signed [11:0] out_x;
    logic signed [11:0] out_y;
    logic               out_kind;
    logic [1:0]         frame;
    logic [8:0]         in_use;
  } out_item_t;

  typedef struct packed {
    logic               active;
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic               kind;
    logic [AGE_W-1:0]   age;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic clr;
  } ring_ctl_t;

endpackage

// ===== rtl/tsp_cell.sv =====
// one slot of the rotating slot ring
module tsp_cell import tsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  ring_ctl_t ctl,
  input  slot_t     din,
  output slot_t     q
);

  logic               active;
  logic signed [11:0] x;
  logic signed [11:0] y;
  logic               kind;
  logic [AGE_W-1:0]   age;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ctl.clr) begin
      active <= 1'b0;
    end else if (ctl.shift) begin
      active <= din.active;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      x    <= din.x;
      y    <= din.y;
      kind <= din.kind;
      age  <= din.age;
    end
  end

  always_comb begin
    q.active = active;
    q.x      = x;
    q.y      = y;
    q.kind   = kind;
    q.age    = age;
  end

endmodule

// ===== rtl/tsp_ctrl.sv =====
// sequencer and head-of-ring processing for the slot pool
module tsp_ctrl import tsp_pkg::*; #(
  parameter int unsigned SLOTS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  in_item_t   req,
  input  logic [7:0] lifetime,
  input  slot_t      head,
  output slot_t      wb,
  output ring_ctl_t  ctl,
  output logic       done,
  output out_item_t  rsp
);

  localparam int unsigned CW = $clog2(SLOTS);
  localparam int unsigned HW = $clog2(SLOTS + 1);
  localparam int unsigned IW = (CW > 8) ? CW : 8;

  state_t          state, state_next;
  in_item_t        arg;
  logic [CW-1:0]   cnt;
  logic [HW-1:0]   hw, hw_next;
  logic            found, found_next;
  logic [CW-1:0]   claim, claim_next;
  logic            top_free, top_free_next;
  logic            rd_hit, rd_hit_next;
  slot_t           rd, rd_next;
  out_item_t       rsp_next;
  logic            accept;
  logic            last;
  logic [AGE_W-1:0] age_inc;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && (state == ST_IDLE);
  assign last    = (cnt == CW'(SLOTS - 1));
  assign age_inc = head.age + AGE_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hw    <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      hw    <= hw_next;
      if (accept || last) begin
        cnt <= '0;
      end else if (state == ST_RUN) begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      arg <= req;
    end
    found    <= found_next;
    claim    <= claim_next;
    top_free <= top_free_next;
    rd_hit   <= rd_hit_next;
    rd       <= rd_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && req.func == FN_CLEAR) || (state == ST_RUN && last);
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

  always_comb begin
    state_next    = state;
    hw_next       = hw;
    found_next    = found;
    claim_next    = claim;
    top_free_next = top_free;
    rd_hit_next   = rd_hit;
    rd_next       = rd;
    wb            = head;
    ctl.shift     = 1'b0;
    ctl.clr       = 1'b0;
    rsp_next      = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          found_next    = 1'b0;
          claim_next    = '0;
          top_free_next = 1'b0;
          rd_hit_next   = 1'b0;
          rd_next       = '0;
          if (req.func == FN_CLEAR) begin
            ctl.clr = 1'b1;
            hw_next = '0;
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        ctl.shift = 1'b1;
        unique case (arg.func)
          FN_ADD: begin
            if (!found && !head.active) begin
              wb.active  = 1'b1;
              wb.x       = arg.pos_x;
              wb.y       = arg.pos_y;
              wb.kind    = arg.kind;
              wb.age     = '0;
              found_next = 1'b1;
              claim_next = cnt;
              if (HW'(cnt) >= hw) begin
                hw_next = HW'(cnt) + HW'(1);
              end
            end
          end
          FN_TICK: begin
            if (HW'(cnt) < hw && head.active) begin
              wb.age    = age_inc;
              wb.active = (age_inc <= {1'b0, lifetime});
            end
            // remember whether the topmost covered slot ends up free
            if (hw != '0 && HW'(cnt) == hw - HW'(1)) begin
              top_free_next = !wb.active;
            end
            if (last && hw != '0 && top_free_next) begin
              hw_next = hw - HW'(1);
            end
          end
          FN_READ: begin
            if (IW'(arg.slot_index) == IW'(cnt) && head.active) begin
              rd_hit_next = 1'b1;
              rd_next     = head;
            end
          end
          default: begin
          end
        endcase
        if (last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (state == ST_RUN && last) begin
      case (arg.func)
        FN_ADD: begin
          rsp_next.ok       = found_next;
          rsp_next.slot_out = found_next ? 8'(claim_next) : 8'd0;
        end
        FN_READ: begin
          rsp_next.ok       = rd_hit_next;
          rsp_next.slot_out = arg.slot_index;
          rsp_next.out_x    = rd_next.x;
          rsp_next.out_y    = rd_next.y;
          rsp_next.out_kind = rd_next.kind;
          rsp_next.frame    = 2'(rd_next.age % FRAMES);
        end
        default: begin
        end
      endcase
    end
    rsp_next.in_use = 9'(hw_next);
  end

endmodule

// ===== rtl/timed_slot_pool_unit.sv =====
// timed slot pool: top level with the slot ring, sequencer and lifetime register
//
//  channel   signals                       accepted when
//  item in   start, busy, req              start && !busy
//  result    done, rsp                     done (one cycle, no back-pressure)
//  config    cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready (always ready)
//
// add, tick and read rotate the whole ring of SLOTS cells once through the head unit;
// busy for the whole pass, no new item taken; result in the following cycle.
// clear frees every slot at once: result in the next cycle, one cycle per item.
// reset (synchronous, rst high) frees all slots, zeroes the high-water mark and
// sets lifetime to 13; no clearing pass is needed.
// done is a one-cycle strobe; the receiver cannot stall it.
module timed_slot_pool_unit import tsp_pkg::*; #(
  parameter int unsigned SLOTS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  in_item_t   req,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output logic       done,
  output out_item_t  rsp
);

  logic [7:0] lifetime;
  slot_t      ring [SLOTS];
  slot_t      wb;
  ring_ctl_t  ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime <= LIFETIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      lifetime <= cfg_data;
    end
  end

  // slot i takes slot i+1 each run cycle; the head result refills the tail
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    slot_t din;
    if (i == SLOTS - 1) begin : g_tail
      assign din = wb;
    end else begin : g_mid
      assign din = ring[i+1];
    end
    tsp_cell u_cell (
      .clk (clk),
      .rst (rst),
      .ctl (ctl),
      .din (din),
      .q   (ring[i])
    );
  end

  tsp_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .lifetime (lifetime),
    .head     (ring[0]),
    .wb       (wb),
    .ctl      (ctl),
    .done     (done),
    .rsp      (rsp)
  );

endmodule
